/* hw/rtl/huffman_tree_decoder_top_defines.svh */
// Assertion macros for the Huffman tree decoder.
// Used by huffman_tree_decoder_top; the macros expect clk and rst_n in scope.
`ifndef HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define HTD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htd assertion failed");

// Next-cycle implication, checked outside reset.
`define HTD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htd assertion failed");

`else

`define HTD_ASSERT_IMP(lbl, ante, cons)
`define HTD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/htd_pkg.sv */
// Shared types and constants of the Huffman tree decoder.
// No dependencies; imported by htd_datapath, htd_ctrl and huffman_tree_decoder_top.
`timescale 1ns / 1ps

package htd_pkg;

    // Fixed field widths of the request and result items.
    localparam int OP_W          = 2;
    localparam int FIELD_IDX_W   = 9;
    localparam int SYM_W         = 8;
    localparam int CNT_W         = 32;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int DEF_NODE_COUNT = 512;

    // Input tdata layout, lowest bit first.
    localparam int NODE_INDEX_LSB = 0;
    localparam int NODE_LEAF_BIT  = 9;
    localparam int NODE_SYM_LSB   = 10;
    localparam int LEFT_LSB       = 18;
    localparam int RIGHT_LSB      = 27;
    localparam int CODE_LSB       = 36;
    localparam int IN_DATA_W      = 48;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROOT_NODE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_TOTAL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // capture the code byte, read the current node
        logic move;      // step to the child picked by the code bit
        logic emit;      // emit the leaf symbol, return to the root
        logic adv;       // go on to the next code bit
        logic flush;     // hand the held symbol out as last of byte
        logic table_wr;  // write a node table entry
        logic restart;   // restart the stream
        logic mark_fin;  // stream has ended, latch finished
    } htd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stopped;      // stream already ended
        logic ent_leaf;     // node entry on the read port is a leaf
        logic moved;        // the current code bit has already stepped
        logic last_bit;     // working on the last code bit of the byte
        logic can_emit;     // room to take one more symbol
        logic reach_total;  // the next symbol reaches the total
        logic pend_valid;   // a symbol is held back
        logic out_free;     // output register can be loaded this cycle
    } htd_status_t;

endpackage

/* hw/rtl/htd_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies; the read data holds when no read is issued.
`timescale 1ns / 1ps

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/htd_datapath.sv */
// Datapath of the Huffman tree decoder: node table, walk registers,
// configuration, held symbol and output register. Depends on htd_pkg, htd_ram.
`timescale 1ns / 1ps

module htd_datapath
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  htd_cmd_t              cmd,
    output htd_status_t           st,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [SYM_W-1:0]      out_symbol,
    output logic                  out_last,
    output logic                  out_done
);

    localparam int IDX_W    = $clog2(NODE_COUNT);
    localparam int ENTRY_W  = 1 + SYM_W + 2 * IDX_W;
    localparam int RECIP_SH = 22;
    localparam int PROD_W   = FIELD_IDX_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((2 ** RECIP_SH) / NODE_COUNT + 1);

    // Index modulo the table size. The scaled reciprocal gives the exact
    // quotient for every 9-bit index, so one multiply-back suffices.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [FIELD_IDX_W-1:0] v);
        logic [PROD_W-1:0]      prod;
        logic [FIELD_IDX_W-1:0] quot;
        logic [FIELD_IDX_W-1:0] rem;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        quot = prod[PROD_W-1:RECIP_SH];
        rem  = v - FIELD_IDX_W'(quot * NODE_COUNT);
        return IDX_W'(rem);
    endfunction

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              moved_reg, moved_next;
    logic [BIT_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [SYM_W-1:0]  byte_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              fin_reg, fin_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg;
    logic              pend_done_reg;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;
    logic               re;
    logic               ent_leaf;
    logic [SYM_W-1:0]   ent_sym;
    logic [IDX_W-1:0]   ent_left;
    logic [IDX_W-1:0]   ent_right;
    logic [IDX_W-1:0]   child;
    logic [CNT_W-1:0]   count_plus;
    logic               reach;
    logic               out_free;

    assign ent_right = rdata[IDX_W-1:0];
    assign ent_left  = rdata[2*IDX_W-1:IDX_W];
    assign ent_sym   = rdata[2*IDX_W+SYM_W-1:2*IDX_W];
    assign ent_leaf  = rdata[ENTRY_W-1];
    assign child     = byte_reg[bit_idx_reg] ? ent_right : ent_left;

    assign count_plus = count_reg + CNT_W'(1);
    assign reach      = (count_plus >= total_reg);
    assign out_free   = !out_valid_reg || out_ready;

    assign waddr = wrap_idx(in_data[NODE_INDEX_LSB +: FIELD_IDX_W]);
    assign wdata = {in_data[NODE_LEAF_BIT],
                    in_data[NODE_SYM_LSB +: SYM_W],
                    wrap_idx(in_data[LEFT_LSB +: FIELD_IDX_W]),
                    wrap_idx(in_data[RIGHT_LSB +: FIELD_IDX_W])};

    assign re    = cmd.start || cmd.move || cmd.emit;
    assign raddr = cmd.start ? cur_reg : (cmd.move ? child : root_reg);

    htd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (cmd.table_wr),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        st.stopped     = fin_reg || (count_reg >= total_reg);
        st.ent_leaf    = ent_leaf;
        st.moved       = moved_reg;
        st.last_bit    = (bit_idx_reg == '0);
        st.can_emit    = !pend_valid_reg || out_free;
        st.reach_total = reach;
        st.pend_valid  = pend_valid_reg;
        st.out_free    = out_free;
    end

    always_comb
    begin
        cur_next        = cur_reg;
        moved_next      = moved_reg;
        bit_idx_next    = bit_idx_reg;
        count_next      = count_reg;
        fin_next        = fin_reg;
        root_next       = root_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_ROOT_NODE:    root_next  = wrap_idx(cfg_wdata[FIELD_IDX_W-1:0]);
                CFG_SYMBOL_TOTAL: total_next = cfg_wdata;
                default:          ;
            endcase
        end

        if (cmd.restart)
        begin
            cur_next   = root_reg;
            count_next = '0;
            fin_next   = 1'b0;
        end
        if (cmd.mark_fin)
        begin
            fin_next = 1'b1;
        end
        if (cmd.start)
        begin
            bit_idx_next = BIT_W'(BITS_PER_BYTE - 1);
            moved_next   = 1'b0;
        end
        if (cmd.move)
        begin
            cur_next   = child;
            moved_next = 1'b1;
        end
        if (cmd.adv)
        begin
            bit_idx_next = bit_idx_reg - BIT_W'(1);
            moved_next   = 1'b0;
        end
        if (cmd.emit)
        begin
            count_next      = count_plus;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
            end
            if (reach)
            begin
                fin_next = 1'b1;
            end
            else
            begin
                cur_next     = root_reg;
                bit_idx_next = bit_idx_reg - BIT_W'(1);
                moved_next   = 1'b0;
            end
        end
        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            moved_reg      <= 1'b0;
            bit_idx_reg    <= '0;
            count_reg      <= '0;
            fin_reg        <= 1'b0;
            root_reg       <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            moved_reg      <= moved_next;
            bit_idx_reg    <= bit_idx_next;
            count_reg      <= count_next;
            fin_reg        <= fin_next;
            root_reg       <= root_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            byte_reg <= in_data[CODE_LSB +: SYM_W];
        end
        if (cmd.emit)
        begin
            pend_sym_reg  <= ent_sym;
            pend_done_reg <= reach;
            if (pend_valid_reg)
            begin
                out_sym_reg  <= pend_sym_reg;
                out_last_reg <= 1'b0;
                out_done_reg <= pend_done_reg;
            end
        end
        if (cmd.flush)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= 1'b1;
            out_done_reg <= pend_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign out_last   = out_last_reg;
    assign out_done   = out_done_reg;

endmodule

/* hw/rtl/htd_ctrl.sv */
// Controller of the Huffman tree decoder: sequences the bit walk.
// Depends on htd_pkg; drives the datapath through htd_cmd_t.
`timescale 1ns / 1ps

module htd_ctrl
    import htd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    output logic            in_ready,
    input  htd_status_t     st,
    output htd_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_WRITE:   cmd.table_wr = 1'b1;
                        OP_RESTART: cmd.restart  = 1'b1;
                        OP_DECODE:
                        begin
                            if (st.stopped)
                            begin
                                cmd.mark_fin = 1'b1;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = ST_EVAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (!st.moved && !st.ent_leaf)
                begin
                    cmd.move = 1'b1;
                end
                else if (st.ent_leaf)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit = 1'b1;
                        if (st.reach_total || st.last_bit)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
                else if (st.last_bit)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/huffman_tree_decoder_top.sv */
// Huffman tree decoder over a host-loaded node table: a request carries a node
// write, a restart or one code byte that is walked most significant bit first,
// emitting one result per decoded symbol. Write and restart requests are handled
// in the idle state. A decode request reads the current node, then for each
// code bit reads the child picked by the bit and tests it: a leaf is emitted
// and the walk returns to the root, else the walk goes on to the next bit. A
// bit that starts on a leaf emits it without a child read; a last step closes
// the byte. The decode time is set by the chain of dependent node table reads
// through the single registered read port of the table RAM; a full output
// register that is not taken stalls the walk. The last symbol of each byte is
// held back so that it can be marked as last of byte, and the next request is
// accepted while that symbol still waits on the output side. The table has no
// reset: only entries already written may be reached by the walk.
// Depends on htd_pkg, htd_ctrl, htd_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_decoder_top_defines.svh"

module huffman_tree_decoder_top
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port: index 0 root_node, index 1 symbol_total.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: node_index[8:0], node_is_leaf[9], node_symbol[17:10],
    // left_child[26:18], right_child[35:27], code_byte[43:36], zero pad[47:44].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0].
    input  logic [OP_W-1:0]       s_axis_tuser,

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: symbol[7:0].
    output logic [SYM_W-1:0]      m_axis_tdata,
    // tlast: last_of_byte.
    output logic                  m_axis_tlast,
    // tuser: stream_done[0].
    output logic                  m_axis_tuser
);

    htd_cmd_t    cmd;
    htd_status_t st;

    // The controller owns the request handshake and the walk sequence.
    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the node table, the walk position, the counters and
    // the output register.
    htd_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_axis_tdata),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_symbol (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_done   (m_axis_tuser)
    );

    // A symbol is only emitted when the held symbol can move to the output.
    `HTD_ASSERT_IMP(a_emit_room, cmd.emit && st.pend_valid, st.out_free)
    // Closing a byte never overwrites a result that has not been taken.
    `HTD_ASSERT_IMP(a_flush_room, cmd.flush, st.out_free)
    // The walk steps are exclusive in any one cycle.
    `HTD_ASSERT_IMP(a_step_excl, 1'b1, ($onehot0({cmd.start, cmd.move, cmd.emit, cmd.adv, cmd.flush})))
    // A decode request that starts a walk makes the block busy.
    `HTD_ASSERT_NXT(a_busy_decode, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_DECODE) && !st.stopped, !s_axis_tready)

endmodule
